>>> hdl/gasc_pkg.sv
// ============================================================================
// gasc_pkg
// Shared widths, constants, state encoding and control structs for the
// skin-conductance averaging and smoothing block.
// ============================================================================
`default_nettype none

package gasc_pkg;

    localparam int ADC_BITS   = 12;
    localparam int FACTOR_W   = 17;
    localparam int LEVEL_W    = 28;
    localparam int SMOOTH_W   = 20;
    localparam int COND_W     = 23;
    localparam int DIV_W      = 24;
    localparam int DIVR_W     = 12;
    localparam int PROD_W     = FACTOR_W + LEVEL_W;

    localparam logic [ADC_BITS-1:0] ADC_FULL   = 12'd4095;
    localparam logic [ADC_BITS-1:0] GUARD_HIGH = 12'd4094;
    localparam logic [FACTOR_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 17'd6554;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG_DIV,
        ST_MUL_OLD,
        ST_MUL_NEW,
        ST_COND_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic seed;
        logic accum;
        logic group_start;
        logic avg_load;
        logic mul_old;
        logic mul_new;
        logic cond_start;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic seeded;
        logic last_sample;
        logic div_busy;
        logic guard;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/gasc_divider.sv
// ============================================================================
// gasc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module gasc_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [gasc_pkg::DIV_W-1:0]    dividend,
    input  wire logic [gasc_pkg::DIVR_W-1:0]   divisor,
    output logic                               busy,
    output logic [gasc_pkg::DIV_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(gasc_pkg::DIV_W + 1);

    logic                          busy_reg, busy_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [gasc_pkg::DIVR_W-1:0]   rem_reg, rem_next;
    logic [gasc_pkg::DIVR_W-1:0]   dvsr_reg, dvsr_next;
    logic [gasc_pkg::DIV_W-1:0]    quo_reg, quo_next;
    logic [gasc_pkg::DIVR_W:0]     trial;
    logic [gasc_pkg::DIVR_W:0]     trial_sub;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[gasc_pkg::DIV_W-1]};
        trial_sub = trial - {1'b0, dvsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(gasc_pkg::DIV_W);
            rem_next  = '0;
            dvsr_next = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            // remainder stays below a nonzero divisor
            if (trial >= {1'b0, dvsr_reg})
            begin
                rem_next = trial_sub[gasc_pkg::DIVR_W-1:0];
                quo_next = {quo_reg[gasc_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[gasc_pkg::DIVR_W-1:0];
                quo_next = {quo_reg[gasc_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hdl/gasc_datapath.sv
// ============================================================================
// gasc_datapath
// Sample accumulator, reciprocal-multiply group mean, moving-average
// multiplier, conductance divider and result registers.
// ============================================================================
`default_nettype none

module gasc_datapath #(
    parameter int SAMPLES_PER_READING = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire gasc_pkg::ctrl_cmd_t               cmd,
    output gasc_pkg::dp_status_t                   status,
    input  wire logic [gasc_pkg::ADC_BITS-1:0]     adc_sample,
    input  wire logic                              cfg_wr_en,
    input  wire logic [gasc_pkg::FACTOR_W-1:0]     cfg_wr_data,
    output logic [gasc_pkg::ADC_BITS-1:0]          average_raw,
    output logic [gasc_pkg::SMOOTH_W-1:0]          smoothed_level,
    output logic [gasc_pkg::COND_W-1:0]            conductance,
    output logic                                   guard_hit
);

    localparam int SUM_W = $clog2(4095 * SAMPLES_PER_READING + 1);
    localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    // ceil(2^22 / n) gives an exact floor mean for any sum below 2^17
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((2 ** RECIP_SHIFT + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);
    localparam int AVG_PROD_W  = SUM_W + RECIP_W;

    logic [gasc_pkg::FACTOR_W-1:0]  factor_reg, factor_next;
    logic                           seeded_reg, seeded_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [gasc_pkg::LEVEL_W-1:0]   level_reg, level_next;
    logic [gasc_pkg::LEVEL_W-1:0]   acc_reg, acc_next;
    logic [gasc_pkg::ADC_BITS-1:0]  avg_reg, avg_next;

    logic [gasc_pkg::ADC_BITS-1:0]  out_avg_reg;
    logic [gasc_pkg::SMOOTH_W-1:0]  out_smooth_reg;
    logic [gasc_pkg::COND_W-1:0]    out_cond_reg;
    logic                           out_guard_reg;

    logic [SUM_W-1:0]               sum_plus;
    logic [AVG_PROD_W-1:0]          avg_prod;
    logic [gasc_pkg::FACTOR_W-1:0]  weight;
    logic [gasc_pkg::FACTOR_W-1:0]  weight_inv;
    logic [gasc_pkg::FACTOR_W-1:0]  mul_a;
    logic [gasc_pkg::LEVEL_W-1:0]   mul_b;
    logic [gasc_pkg::PROD_W-1:0]    product;
    logic                           guard;
    logic [gasc_pkg::DIV_W-1:0]     cond_num;

    logic                           div_start;
    logic [gasc_pkg::DIV_W-1:0]     div_dividend;
    logic [gasc_pkg::DIVR_W-1:0]    div_divisor;
    logic                           div_busy;
    logic [gasc_pkg::DIV_W-1:0]     div_quotient;

    gasc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_comb
    begin
        sum_plus   = sum_reg + SUM_W'(adc_sample);
        avg_prod   = AVG_PROD_W'(sum_reg) * AVG_PROD_W'(RECIP);
        weight     = (factor_reg > gasc_pkg::ONE_Q16) ? gasc_pkg::ONE_Q16 : factor_reg;
        weight_inv = gasc_pkg::ONE_Q16 - weight;
        // one shared multiplier: old level term first, new average term second
        mul_a      = cmd.mul_old ? weight_inv : weight;
        mul_b      = cmd.mul_old ? level_reg : gasc_pkg::LEVEL_W'(avg_reg);
        product    = gasc_pkg::PROD_W'(mul_a) * gasc_pkg::PROD_W'(mul_b);
        guard      = (avg_reg == '0) || (avg_reg >= gasc_pkg::GUARD_HIGH);
        // 2560 * avg as two shifted copies
        cond_num   = (gasc_pkg::DIV_W'(avg_reg) << 11) + (gasc_pkg::DIV_W'(avg_reg) << 9);

        div_start    = cmd.cond_start;
        div_dividend = cond_num;
        div_divisor  = gasc_pkg::ADC_FULL - avg_reg;

        factor_next = cfg_wr_en ? cfg_wr_data : factor_reg;
        seeded_next = seeded_reg || cmd.seed;
        sum_next    = sum_reg;
        count_next  = count_reg;
        if (cmd.accum)
        begin
            sum_next   = sum_plus;
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.group_start)
        begin
            // keep the full group sum for the mean
            sum_next   = sum_plus;
            count_next = '0;
        end
        else if (cmd.avg_load)
        begin
            sum_next   = '0;
        end

        level_next = level_reg;
        if (cmd.seed)
            level_next = {adc_sample, 16'b0};
        else if (cmd.mul_new)
            level_next = acc_reg + product[gasc_pkg::LEVEL_W-1:0];

        acc_next = cmd.mul_old ? product[gasc_pkg::LEVEL_W+15:16] : acc_reg;
        avg_next = cmd.avg_load ? avg_prod[RECIP_SHIFT +: gasc_pkg::ADC_BITS] : avg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= gasc_pkg::FACTOR_RST;
            seeded_reg <= 1'b0;
            sum_reg    <= '0;
            count_reg  <= '0;
            level_reg  <= '0;
        end
        else
        begin
            factor_reg <= factor_next;
            seeded_reg <= seeded_next;
            sum_reg    <= sum_next;
            count_reg  <= count_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        avg_reg <= avg_next;
        if (cmd.out_load)
        begin
            out_avg_reg    <= avg_reg;
            out_smooth_reg <= level_reg[gasc_pkg::LEVEL_W-1:8];
            out_cond_reg   <= guard ? '0 : div_quotient[gasc_pkg::COND_W-1:0];
            out_guard_reg  <= guard;
        end
    end

    assign status.seeded      = seeded_reg;
    assign status.last_sample = (count_reg == CNT_W'(SAMPLES_PER_READING - 1));
    assign status.div_busy    = div_busy;
    assign status.guard       = guard;

    assign average_raw    = out_avg_reg;
    assign smoothed_level = out_smooth_reg;
    assign conductance    = out_cond_reg;
    assign guard_hit      = out_guard_reg;

endmodule

`default_nettype wire

>>> hdl/gasc_ctrl.sv
// ============================================================================
// gasc_ctrl
// Sequencer for seeding, accumulation, averaging, smoothing and conductance.
// ============================================================================
`default_nettype none

module gasc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire gasc_pkg::dp_status_t   status,
    output gasc_pkg::ctrl_cmd_t         cmd
);

    gasc_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;
    logic             in_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gasc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        in_fire        = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            gasc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                in_fire  = in_valid;
                if (in_fire)
                begin
                    if (!status.seeded)
                        cmd.seed = 1'b1;
                    else if (!status.last_sample)
                        cmd.accum = 1'b1;
                    else
                    begin
                        cmd.group_start = 1'b1;
                        state_next      = gasc_pkg::ST_AVG_DIV;
                    end
                end
            end
            gasc_pkg::ST_AVG_DIV:
            begin
                cmd.avg_load = 1'b1;
                state_next   = gasc_pkg::ST_MUL_OLD;
            end
            gasc_pkg::ST_MUL_OLD:
            begin
                cmd.mul_old = 1'b1;
                state_next  = gasc_pkg::ST_MUL_NEW;
            end
            gasc_pkg::ST_MUL_NEW:
            begin
                cmd.mul_new = 1'b1;
                if (status.guard)
                    state_next = gasc_pkg::ST_DONE;
                else
                begin
                    cmd.cond_start = 1'b1;
                    state_next     = gasc_pkg::ST_COND_DIV;
                end
            end
            gasc_pkg::ST_COND_DIV:
            begin
                if (!status.div_busy)
                    state_next = gasc_pkg::ST_DONE;
            end
            gasc_pkg::ST_DONE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = gasc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gasc_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/gsr_average_smooth_conductance.sv
// ============================================================================
// gsr_average_smooth_conductance
// Boxcar average of ADC samples feeding a Q12.16 moving average and a
// conductance estimate, controller plus datapath with a shared multiplier.
// ============================================================================
// a sample that does not close a group is taken and the controller stays idle
// a group-closing request is averaged, smoothed, then the 24-step bit-serial
//   conductance divider runs unless guarded; a free output register then loads
// a new request is taken while a result waits in the output register
// reset: async active low, clears the filter, group count and seed flag,
//   loads the smoothing factor with 6554
`default_nettype none

module gsr_average_smooth_conductance #(
    parameter int SAMPLES_PER_READING = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [gasc_pkg::ADC_BITS-1:0]     adc_sample,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [gasc_pkg::ADC_BITS-1:0]          average_raw,
    output logic [gasc_pkg::SMOOTH_W-1:0]          smoothed_level,
    output logic [gasc_pkg::COND_W-1:0]            conductance,
    output logic                                   guard_hit,
    input  wire logic                              cfg_wr_en,
    input  wire logic [gasc_pkg::FACTOR_W-1:0]     cfg_wr_data
);

    gasc_pkg::ctrl_cmd_t  cmd;
    gasc_pkg::dp_status_t status;

    gasc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    gasc_datapath #(
        .SAMPLES_PER_READING (SAMPLES_PER_READING)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .adc_sample     (adc_sample),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .average_raw    (average_raw),
        .smoothed_level (smoothed_level),
        .conductance    (conductance),
        .guard_hit      (guard_hit)
    );

    // divider is never running while requests are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !status.div_busy)
        else $error("divider busy while accepting requests");

    // a new result only appears after an output load
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result valid without output load");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && guard_hit) |-> (conductance == '0))
        else $error("guarded result with nonzero conductance");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !guard_hit) |-> (average_raw != '0))
        else $error("zero average without guard flag");

endmodule

`default_nettype wire
